### sv/cvb_pkg.sv
// Package with word types and constants of the cylinder velocity binner.
`default_nettype none
package cvb_pkg;
	localparam logic [1:0] ACT_SET   = 2'd0;
	localparam logic [1:0] ACT_PART  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_READ  = 2'd3;

	localparam logic [2:0] CFG_BIN_COUNT   = 3'd0;
	localparam logic [2:0] CFG_RADIUS_STEP = 3'd1;
	localparam logic [2:0] CFG_HALF_LENGTH = 3'd2;
	localparam logic [2:0] CFG_BOX_SIZE    = 3'd3;
	localparam logic [2:0] CFG_PERIODIC    = 3'd4;

	localparam logic signed [47:0] SUM_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] SUM_MIN = 48'sh8000_0000_0000;

	typedef struct packed {
		logic [1:0]         action;
		logic [31:0]        pos_x;
		logic [31:0]        pos_y;
		logic [31:0]        pos_z;
		logic signed [23:0] vel_x;
		logic signed [23:0] vel_y;
		logic signed [23:0] vel_z;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
		logic [2:0]         bin_select;
	} in_word_t;

	typedef struct packed {
		logic [3:0]         bins_hit;
		logic [31:0]        bin_particles;
		logic signed [47:0] sum_x;
		logic signed [47:0] sum_y;
		logic signed [47:0] sum_z;
	} out_word_t;

	// Classified command passed from the geometry front to the accumulator back.
	typedef struct packed {
		logic [1:0]         action;
		logic [3:0]         hits;
		logic [2:0]         sel;
		logic signed [23:0] vel_x;
		logic signed [23:0] vel_y;
		logic signed [23:0] vel_z;
	} cmd_t;
endpackage
`default_nettype wire

### sv/cvb_front.sv
// Geometry front end: offsets, wrap, projection and shell classification.
`default_nettype none
module cvb_front import cvb_pkg::*; #(
	parameter int MAX_BINS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire in_word_t    in_word,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [3:0]  bin_count,
	input  wire logic [31:0] radius_step,
	input  wire logic [31:0] half_length,
	input  wire logic [31:0] box_size,
	input  wire logic        periodic_mode,
	output cmd_t             cmd,
	output logic             cmd_valid,
	input  wire logic        cmd_ready
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_OFF  = 4'd1;
	localparam logic [3:0] ST_SQ   = 4'd2;
	localparam logic [3:0] ST_SUM  = 4'd3;
	localparam logic [3:0] ST_CHK  = 4'd4;
	localparam logic [3:0] ST_RMUL = 4'd5;
	localparam logic [3:0] ST_RSQ  = 4'd6;
	localparam logic [3:0] ST_CMP  = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	logic [3:0] state_q;
	in_word_t w_q;
	logic signed [33:0] d_q [3];
	logic signed [49:0] pr_q [3];
	logic [63:0] sq_q [3];
	logic signed [51:0] dot_q;
	logic [65:0] len2_q;
	logic [103:0] dot2_q;
	logic [96:0] dis_q;
	logic [3:0] n_q, j_q, hits_q;
	logic [35:0] r_q;
	logic [71:0] rsq_q;
	logic [1:0] k_q;

	logic [3:0] n_c;
	logic signed [33:0] draw, dw;
	logic [31:0] pk;
	logic [33:0] dmag;
	logic [51:0] dotmag;
	logic signed [51:0] hq;
	logic [103:0] len2s;
	logic [101:0] thr;

	assign n_c = (int'(bin_count) > MAX_BINS) ? 4'(MAX_BINS) : bin_count;
	assign in_ready = (state_q == ST_IDLE);
	assign hq = 52'(half_length) <<< 15;
	assign dotmag = dot_q[51] ? 52'(-dot_q) : 52'(dot_q);
	assign len2s = 104'(len2_q) << 30;
	assign thr = 102'(rsq_q) << 30;

	always_comb begin
		unique case (k_q)
			2'd0: pk = w_q.pos_x;
			2'd1: pk = w_q.pos_y;
			default: pk = w_q.pos_z;
		endcase
	end

	// Centre and axis registers.
	logic [31:0] cen_q [3];
	logic signed [15:0] ax_q [3];
	logic [31:0] cen_k;
	assign cen_k = cen_q[k_q];
	assign draw = $signed({2'b00, pk}) - $signed({2'b00, cen_k});
	always_comb begin
		dw = draw;
		if (periodic_mode) begin
			if ((draw <<< 1) > $signed({2'b00, box_size}))
				dw = draw - $signed({2'b00, box_size});
			else if ((draw <<< 1) < -$signed({2'b00, box_size}))
				dw = draw + $signed({2'b00, box_size});
		end
	end
	assign dmag = d_q[k_q][33] ? 34'(-d_q[k_q]) : 34'(d_q[k_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_valid <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				cen_q[i] <= '0;
				ax_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) begin
					w_q <= in_word;
					k_q <= 2'd0;
					n_q <= n_c;
					if (in_word.action == ACT_SET) begin
						cen_q[0] <= in_word.pos_x;
						cen_q[1] <= in_word.pos_y;
						cen_q[2] <= in_word.pos_z;
						ax_q[0] <= in_word.axis_x;
						ax_q[1] <= in_word.axis_y;
						ax_q[2] <= in_word.axis_z;
					end
					hits_q <= '0;
					state_q <= (in_word.action == ACT_PART) ? ST_OFF : ST_OUT;
				end
				ST_OFF: begin
					d_q[k_q] <= dw;
					state_q <= ST_SQ;
				end
				ST_SQ: begin
					pr_q[k_q] <= 50'(d_q[k_q] * ax_q[k_q]);
					sq_q[k_q] <= 64'(dmag * dmag);
					if (k_q == 2'd2) state_q <= ST_SUM;
					else begin k_q <= k_q + 2'd1; state_q <= ST_OFF; end
				end
				ST_SUM: begin
					dot_q <= 52'(pr_q[0]) + 52'(pr_q[1]) + 52'(pr_q[2]);
					len2_q <= 66'(sq_q[0]) + 66'(sq_q[1]) + 66'(sq_q[2]);
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					// The projection magnitude is under 2^51, so its square is built
					// from three 26-bit partial products.
					dot2_q <= 104'(dotmag[25:0] * dotmag[25:0])
						+ (104'(dotmag[51:26] * dotmag[25:0]) << 27)
						+ (104'(dotmag[51:26] * dotmag[51:26]) << 52);
					if (dot_q < -hq || dot_q > hq) state_q <= ST_OUT;
					else state_q <= ST_RMUL;
					j_q <= '0;
				end
				ST_RMUL: begin
					if (!(dot2_q < len2s)) state_q <= ST_OUT;
					else begin
						dis_q <= 97'(len2s - dot2_q);
						r_q <= 36'(n_q - j_q) * 36'(radius_step);
						state_q <= (j_q < n_q) ? ST_RSQ : ST_OUT;
					end
				end
				ST_RSQ: begin
					rsq_q <= r_q * r_q;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (102'(dis_q) < thr) begin
						hits_q <= hits_q + 4'd1;
						j_q <= j_q + 4'd1;
						if (j_q + 4'd1 < n_q) begin
							r_q <= 36'(n_q - j_q - 4'd1) * 36'(radius_step);
							state_q <= ST_RSQ;
						end else state_q <= ST_OUT;
					end else state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!cmd_valid) cmd_valid <= 1'b1;
					else if (cmd_ready) begin
						cmd_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cmd.action = w_q.action;
	assign cmd.hits = hits_q;
	assign cmd.sel = w_q.bin_select;
	assign cmd.vel_x = w_q.vel_x;
	assign cmd.vel_y = w_q.vel_y;
	assign cmd.vel_z = w_q.vel_z;
endmodule
`default_nettype wire

### sv/cvb_back.sv
// Accumulator back end: shell sums, clear, read and the output register.
`default_nettype none
module cvb_back import cvb_pkg::*; #(
	parameter int MAX_BINS = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire logic cmd_valid,
	output logic      cmd_ready,
	output out_word_t out_word,
	output logic      out_valid,
	input  wire logic out_ready
);
	logic [31:0] cnt_q [MAX_BINS];
	logic signed [47:0] sx_q [MAX_BINS], sy_q [MAX_BINS], sz_q [MAX_BINS];
	out_word_t res_c;

	function automatic logic signed [47:0] sat(input logic signed [47:0] s,
		input logic signed [23:0] v);
		logic signed [48:0] t;
		t = 49'(s) + 49'(v);
		if (t > 49'(SUM_MAX)) return SUM_MAX;
		if (t < 49'(SUM_MIN)) return SUM_MIN;
		return t[47:0];
	endfunction

	assign cmd_ready = !out_valid || out_ready;

	// Result word of the waiting command, taken from the sums before it changes them.
	always_comb begin
		res_c = '0;
		unique case (cmd.action)
			ACT_PART: res_c.bins_hit = cmd.hits;
			ACT_READ:
				for (int b = 0; b < MAX_BINS; b++)
					if (b == int'(cmd.sel)) begin
						res_c.bin_particles = cnt_q[b];
						res_c.sum_x = sx_q[b];
						res_c.sum_y = sy_q[b];
						res_c.sum_z = sz_q[b];
					end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			for (int b = 0; b < MAX_BINS; b++) begin
				cnt_q[b] <= '0; sx_q[b] <= '0; sy_q[b] <= '0; sz_q[b] <= '0;
			end
		end else begin
			if (cmd_valid && cmd_ready) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (cmd_valid && cmd_ready) begin
				out_word <= res_c;
				unique case (cmd.action)
					ACT_PART:
						for (int b = 0; b < MAX_BINS; b++)
							if (b < int'(cmd.hits)) begin
								if (cnt_q[b] != 32'hFFFF_FFFF) cnt_q[b] <= cnt_q[b] + 32'd1;
								sx_q[b] <= sat(sx_q[b], cmd.vel_x);
								sy_q[b] <= sat(sy_q[b], cmd.vel_y);
								sz_q[b] <= sat(sz_q[b], cmd.vel_z);
							end
					ACT_CLEAR:
						for (int b = 0; b < MAX_BINS; b++) begin
							cnt_q[b] <= '0; sx_q[b] <= '0; sy_q[b] <= '0; sz_q[b] <= '0;
						end
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

### sv/cylinder_velocity_binner.sv
// Top level of the cylinder velocity binner.
// Every input word yields exactly one result word, in order. A geometry front end
// takes one word at a time; it walks the three offset axes and then the shell
// radii one by one. A particle word is compared against each shell it hits and,
// unless every shell in use is hit, one more that it misses; a particle whose
// projection is out of range, one on the axis, or one with no shell in use is
// compared against none. Set, clear and read words skip the geometry steps. The
// back end retires one command per cycle into an output register and stalls the
// front end, and with it in_ready, only while that register holds a word nobody
// has taken.
`default_nettype none
module cylinder_velocity_binner import cvb_pkg::*; #(
	parameter int MAX_BINS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire in_word_t    in_word,
	input  wire logic        in_valid,
	output logic             in_ready,
	output out_word_t        out_word,
	output logic             out_valid,
	input  wire logic        out_ready,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	logic [3:0] bin_count_q;
	logic [31:0] radius_step_q, half_length_q, box_size_q;
	logic periodic_q;
	cmd_t cmd;
	logic cmd_valid, cmd_ready;

	// Configuration registers. They are meant to be written only while no word is
	// in flight, since the front end reads them live while it works on a word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_count_q <= 4'd4;
			radius_step_q <= 32'd256000;
			half_length_q <= 32'd128000;
			box_size_q <= 32'd256000000;
			periodic_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BIN_COUNT:   bin_count_q <= cfg_data[3:0];
				CFG_RADIUS_STEP: radius_step_q <= cfg_data;
				CFG_HALF_LENGTH: half_length_q <= cfg_data;
				CFG_BOX_SIZE:    box_size_q <= cfg_data;
				CFG_PERIODIC:    periodic_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// The front end classifies each word and hands a command with the number of
	// shells hit to the back end, which owns all the shell sums.
	cvb_front #(.MAX_BINS(MAX_BINS)) u_front (
		.clk, .arst_n, .in_word, .in_valid, .in_ready,
		.bin_count(bin_count_q), .radius_step(radius_step_q),
		.half_length(half_length_q), .box_size(box_size_q),
		.periodic_mode(periodic_q), .cmd, .cmd_valid, .cmd_ready
	);

	cvb_back #(.MAX_BINS(MAX_BINS)) u_back (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_ready,
		.out_word, .out_valid, .out_ready
	);
endmodule
`default_nettype wire
